// ===== rtl/tone_timer_setting_calculator_macros.svh =====
// Assertion macros shared by the tone timer setting calculator RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TONE_TIMER_SETTING_CALCULATOR_MACROS_SVH
`define TONE_TIMER_SETTING_CALCULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tone timer setting calculator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tone timer setting calculator: next-cycle check failed");

`endif

// ===== rtl/tts_pkg.sv =====
// Package of the tone timer setting calculator: payload types, divider
// request and response types, widths and the prescaler shift table.
// Used by tts_serial_div and tone_timer_setting_calculator.
`timescale 1ns / 1ps

package tts_pkg;

  localparam int unsigned CLOCK_HZ       = 16000000;
  localparam int unsigned FREQ_W         = 16;
  localparam int unsigned DUTY_IN_W      = 8;
  localparam int unsigned DUTY_W         = 7;
  localparam int unsigned TOP_W          = 16;
  localparam int unsigned SEL_W          = 3;
  localparam int unsigned NUM_PRESCALERS = 5;
  localparam int unsigned DIVISOR_W      = FREQ_W;

  // Quotient of twice the clock over the frequency, and top times duty.
  localparam int unsigned QUOT_W  = $clog2(2 * CLOCK_HZ + 1);
  localparam int unsigned PROD_W  = TOP_W + DUTY_W;
  localparam int unsigned DIV_W   = (QUOT_W > PROD_W) ? QUOT_W : PROD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned MUL_CNT_W = $clog2(DUTY_W + 1);

  localparam logic [DIV_W-1:0]     TWO_CLOCK = DIV_W'(2 * CLOCK_HZ);
  localparam logic [TOP_W-1:0]     TOP_SAT   = '1;
  localparam logic [DUTY_W-1:0]    DUTY_MIN  = DUTY_W'(1);
  localparam logic [DUTY_W-1:0]    DUTY_MAX  = DUTY_W'(95);
  localparam logic [DIVISOR_W-1:0] PERCENT   = DIVISOR_W'(100);
  localparam logic [SEL_W-1:0]     SEL_LAST  = SEL_W'(NUM_PRESCALERS - 1);

  localparam logic [SEL_W-1:0] PSC_1    = 3'd0;
  localparam logic [SEL_W-1:0] PSC_8    = 3'd1;
  localparam logic [SEL_W-1:0] PSC_64   = 3'd2;
  localparam logic [SEL_W-1:0] PSC_256  = 3'd3;
  localparam logic [SEL_W-1:0] PSC_1024 = 3'd4;

  typedef struct packed {
    logic [FREQ_W-1:0]    frequency_hz;
    logic [DUTY_IN_W-1:0] duty_percent;
  } tts_in_t;

  typedef struct packed {
    logic             running;
    logic [SEL_W-1:0] prescaler_select;
    logic [TOP_W-1:0] period_top;
    logic [TOP_W-1:0] duty_compare;
  } tts_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } tts_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } tts_div_rsp_t;

  // Base-two logarithm of each prescaler.
  function automatic logic [3:0] prescale_shift(input logic [SEL_W-1:0] sel);
    logic [3:0] sh;
    unique case (sel)
      PSC_1:    sh = 4'd0;
      PSC_8:    sh = 4'd3;
      PSC_64:   sh = 4'd6;
      PSC_256:  sh = 4'd8;
      PSC_1024: sh = 4'd10;
      default:  sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== rtl/tts_serial_div.sv =====
// Bit-serial restoring divider of the tone timer setting calculator.
// One quotient bit per cycle; depends on tts_pkg.
`timescale 1ns / 1ps

module tts_serial_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tts_pkg::tts_div_req_t req_i,
  output tts_pkg::tts_div_rsp_t rsp_o
);
  import tts_pkg::*;

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  // The dividend register shifts out at the top and takes quotient bits in
  // at the bottom, so it holds the quotient once all bits have passed.
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      rem_d = '0;
      cnt_d = DIV_CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dvd_d  = {dvd_q[DIV_W-2:0], ge};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== rtl/tone_timer_setting_calculator.sv =====
// Top level of the tone timer setting calculator: sequencer, prescaler
// search, shift-add multiplier and output register.
// Depends on tts_pkg, tts_serial_div and the assertion macro header.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (tts_in_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (tts_out_t)
//   cfg      input      cfg_we_i                   cfg_wdata_i (output_attached)
//
// One beat is worked on at a time. A running beat goes through the bit-serial divider,
// the prescaler search, which tries the prescalers in turn, the seven-step multiplier
// and the divider again, and its result then waits in S_OUT for the output register;
// the next beat is accepted once that result has been loaded into the output register.
// A stopped beat skips the divider and multiplier and goes straight to S_OUT.
// Reset clears the sequencer, output valid and the attached flag.
// A stalled output holds its beat; the next result waits in the sequencer.
`timescale 1ns / 1ps
`include "tone_timer_setting_calculator_macros.svh"

module tone_timer_setting_calculator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tts_pkg::tts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tts_pkg::tts_out_t out_data_o
);
  import tts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic                 attached_q;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic [SEL_W-1:0]     idx_q, idx_d;
  logic [TOP_W-1:0]     top_q, top_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [DUTY_W-1:0]    mplier_q, mplier_d;
  logic [MUL_CNT_W-1:0] mcnt_q, mcnt_d;
  tts_out_t             res_q, res_d;
  tts_out_t             out_q;
  logic                 out_valid_q;

  tts_div_req_t div_req;
  tts_div_rsp_t div_rsp;

  logic              accept;
  logic              go;
  logic [DUTY_W-1:0] duty_clamped;
  logic [DIV_W-1:0]  shifted;
  logic [DIV_W:0]    q_round;
  logic              fits;
  logic [TOP_W-1:0]  top_try;
  logic [TOP_W-1:0]  cmp_raw;
  logic [TOP_W-1:0]  cmp_lo;
  logic [TOP_W-1:0]  cmp_fin;
  logic              out_load;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign go     = attached_q && (in_data_i.frequency_hz != '0);

  always_comb begin
    if (in_data_i.duty_percent < {1'b0, DUTY_MIN}) begin
      duty_clamped = DUTY_MIN;
    end else if (in_data_i.duty_percent > {1'b0, DUTY_MAX}) begin
      duty_clamped = DUTY_MAX;
    end else begin
      duty_clamped = in_data_i.duty_percent[DUTY_W-1:0];
    end
  end

  // With E = floor(2*CLOCK_HZ / f), the rounded quotient for prescaler 2^k is
  // (floor(E / 2^k) + 1) / 2, which also holds for the odd-denominator case.
  assign shifted = div_rsp.quotient >> prescale_shift(idx_q);
  assign q_round = ({1'b0, shifted} + (DIV_W + 1)'(1)) >> 1;
  assign fits    = (q_round[DIV_W:TOP_W] == '0);

  always_comb begin
    if (!fits) begin
      top_try = TOP_SAT;
    end else if (q_round[DIV_W:1] == '0) begin
      top_try = TOP_W'(1);
    end else begin
      top_try = q_round[TOP_W-1:0] - TOP_W'(1);
    end
  end

  assign cmp_raw = div_rsp.quotient[TOP_W-1:0];
  assign cmp_lo  = (cmp_raw == '0) ? TOP_W'(1) : cmp_raw;
  assign cmp_fin = (cmp_lo >= top_q) ? (top_q - TOP_W'(1)) : cmp_lo;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = TWO_CLOCK;
    div_req.divisor  = in_data_i.frequency_hz;
    if (state_q == S_IDLE) begin
      div_req.start = accept && go;
    end else begin
      div_req.start    = (state_q == S_MUL) && (mcnt_q == '0);
      div_req.dividend = DIV_W'(acc_q);
      div_req.divisor  = PERCENT;
    end
  end

  tts_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    duty_d   = duty_q;
    idx_d    = idx_q;
    top_d    = top_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    mcnt_d   = mcnt_q;
    res_d    = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          duty_d = duty_clamped;
          idx_d  = PSC_1;
          if (go) begin
            state_d = S_DIV1;
          end else begin
            res_d   = '0;
            state_d = S_OUT;
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        if (fits || (idx_q == SEL_LAST)) begin
          top_d    = top_try;
          acc_d    = '0;
          mcand_d  = PROD_W'(top_try);
          mplier_d = duty_q;
          mcnt_d   = MUL_CNT_W'(DUTY_W);
          state_d  = S_MUL;
        end else begin
          idx_d = idx_q + SEL_W'(1);
        end
      end
      S_MUL: begin
        if (mcnt_q != '0) begin
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
          mcnt_d   = mcnt_q - MUL_CNT_W'(1);
        end else begin
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          res_d.running          = 1'b1;
          res_d.prescaler_select = idx_q;
          res_d.period_top       = top_q;
          res_d.duty_compare     = cmp_fin;
          state_d                = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      attached_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        attached_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q   <= duty_d;
    idx_q    <= idx_d;
    top_q    <= top_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    mcnt_q   <= mcnt_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TTS_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `TTS_ASSERT_NOW(a_div_done_expected, div_rsp.done, (state_q == S_DIV1) || (state_q == S_DIV2))
  `TTS_ASSERT_NOW(a_stopped_is_zero, out_valid_o && !out_data_o.running,
                  (out_data_o.prescaler_select == '0) && (out_data_o.period_top == '0) &&
                  (out_data_o.duty_compare == '0))
  `TTS_ASSERT_NOW(a_compare_below_top, out_valid_o && out_data_o.running,
                  (out_data_o.duty_compare < out_data_o.period_top) &&
                  (out_data_o.prescaler_select <= SEL_LAST))

endmodule

// ===== test/tb_tone_timer_setting_calculator.sv =====
// Self-checking testbench for tone_timer_setting_calculator: random and directed
// tone requests, random input gaps and output stalls, checked against a local predictor.
// Depends on tts_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_tone_timer_setting_calculator;
  import tts_pkg::*;

  localparam int unsigned HOLD_AFTER_RESULT = 100;
  localparam int unsigned LONG_HOLD_CYCLES  = 500;
  localparam int unsigned LONG_HOLD_AT      = 120;

  // Keeps the expected timer settings in arrival order and checks each result beat.
  class tone_setting_board;
    tts_out_t    pending_settings[$];
    bit          attached;
    int unsigned errors;
    int unsigned noted;
    int unsigned checked;
    int unsigned running_seen;
    int unsigned stopped_seen;
    bit [4:0]    prescalers_seen;

    function tts_out_t timer_settings_for(tts_in_t beat);
      tts_out_t         s;
      logic [63:0]      denom;
      logic [63:0]      q;
      logic [31:0]      top;
      logic [31:0]      cmp;
      logic [31:0]      duty;
      logic [31:0]      ratio;
      logic [SEL_W-1:0] sel;
      logic [SEL_W-1:0] chosen;
      bit               fits;
      s = '0;
      if (!attached || beat.frequency_hz == '0) return s;
      duty = 32'(beat.duty_percent);
      if (duty < 1) duty = 1;
      if (duty > 95) duty = 95;
      top = 32'hFFFF;
      chosen = PSC_1;
      fits = 1'b0;
      for (int i = 0; i < NUM_PRESCALERS; i++) begin
        if (!fits) begin
          sel = SEL_W'(i);
          case (sel)
            PSC_1:   ratio = 1;
            PSC_8:   ratio = 8;
            PSC_64:  ratio = 64;
            PSC_256: ratio = 256;
            default: ratio = 1024;
          endcase
          denom = 64'(ratio) * 64'(beat.frequency_hz);
          q = (64'(CLOCK_HZ) + denom / 2) / denom;
          if (q < 2) q = 2;
          q = q - 1;
          top = (q > 64'hFFFF) ? 32'hFFFF : q[31:0];
          chosen = sel;
          fits = (top < 32'hFFFF);
        end
      end
      cmp = (top * duty) / 100;
      if (cmp < 1) cmp = 1;
      if (cmp >= top) cmp = top - 1;
      s.running          = 1'b1;
      s.prescaler_select = chosen;
      s.period_top       = top[TOP_W-1:0];
      s.duty_compare     = cmp[TOP_W-1:0];
      return s;
    endfunction

    function void note(tts_in_t beat);
      pending_settings.push_back(timer_settings_for(beat));
      noted++;
    endfunction

    function void complain(string what, int unsigned want, int unsigned got);
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check(tts_out_t got);
      tts_out_t want;
      if (pending_settings.size() == 0) begin
        errors++;
        $display("%0t ns: result beat %h arrived with nothing expected, actual %h",
                 $time, got, got);
        return;
      end
      want = pending_settings.pop_front();
      checked++;
      if (got.running !== want.running)
        complain("running", want.running, got.running);
      if (got.prescaler_select !== want.prescaler_select)
        complain("prescaler_select", want.prescaler_select, got.prescaler_select);
      if (got.period_top !== want.period_top)
        complain("period_top", want.period_top, got.period_top);
      if (got.duty_compare !== want.duty_compare)
        complain("duty_compare", want.duty_compare, got.duty_compare);
      if (want.running) begin
        running_seen++;
        if (want.prescaler_select <= PSC_1024) prescalers_seen[want.prescaler_select] = 1'b1;
      end else begin
        stopped_seen++;
      end
    endfunction

    function int unsigned pending();
      return pending_settings.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_stall_o;
  tts_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tts_out_t out_data_o;

  tone_setting_board board = new();

  tone_timer_setting_calculator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Frequencies lean towards the prescaler boundaries and the low end, where the
  // search walks furthest; the rest spans the whole field.
  function automatic tts_in_t random_beat();
    tts_in_t     b;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       b.frequency_hz = '0;
    else if (r < 25) b.frequency_hz = 16'($urandom_range(1, 40));
    else if (r < 40) b.frequency_hz = 16'($urandom_range(200, 300));
    else if (r < 48) b.frequency_hz = 16'($urandom_range(60, 70));
    else             b.frequency_hz = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 50)      b.duty_percent = 8'($urandom_range(0, 100));
    else if (r < 60) b.duty_percent = 8'($urandom_range(94, 97));
    else             b.duty_percent = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic drive_beat(tts_in_t beat, int unsigned gap);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    board.note(beat);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_attached(bit value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.attached = value;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count, int pause_at);
    int unsigned gap;
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) settle();
      gap = ((k % 64) < 16) ? 0 : gap_length();
      drive_beat(random_beat(), gap);
    end
  endtask

  // Result side: random stall pattern, one long hold-off once the run is under way.
  initial begin : result_side
    int unsigned stall_left;
    bit          long_hold_done;
    int unsigned r;
    stall_left     = 0;
    long_hold_done = 1'b0;
    out_stall_i   <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check(out_data_o);
      if (!long_hold_done && board.checked >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_stall_i   <= 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (stall_left != 0) begin
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_stall_i <= 1'b0;
          stall_left   = 80;
        end else begin
          out_stall_i <= 1'($urandom_range(0, 1));
          stall_left   = gap_length();
        end
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("Timed out with %0d results still expected", board.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned dir_freq[20] = '{0, 1, 1, 2, 3, 4, 30, 31, 244, 245,
                                  440, 1000, 65535, 65535, 65535, 32768, 32767,
                                  16'hAAAA, 16'h5555, 62};
    int unsigned dir_duty[20] = '{50, 0, 255, 95, 96, 1, 50, 50, 50, 50,
                                  0, 100, 255, 0, 95, 128, 127, 8'h55, 8'hAA, 50};
    tts_in_t     beat;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    board.attached = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // With no output attached every request must come back stopped.
    for (int k = 0; k < 3; k++) begin
      beat.frequency_hz = 16'(dir_freq[k * 6 + 1]);
      beat.duty_percent = 8'(dir_duty[k * 6 + 1]);
      drive_beat(beat, gap_length());
    end
    settle();
    write_attached(1'b1);

    for (int k = 0; k < 20; k++) begin
      beat.frequency_hz = 16'(dir_freq[k]);
      beat.duty_percent = 8'(dir_duty[k]);
      drive_beat(beat, gap_length());
    end

    run_random(300, 200);
    settle();
    write_attached(1'b0);
    run_random(60, -1);
    settle();
    write_attached(1'b1);
    run_random(320, -1);
    settle();
    repeat (HOLD_AFTER_RESULT) @(posedge clk_i);

    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t ns: %0d expected results never arrived", $time, board.pending());
    end
    $display("Run covered %0d request beats and %0d result beats: %0d running, %0d stopped",
             board.noted, board.checked, board.running_seen, board.stopped_seen);
    $display("Prescaler choices reached (1024..1): %b, mismatches: %0d",
             board.prescalers_seen, board.errors);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_serial_div.sv
rtl/tone_timer_setting_calculator.sv
test/tb_tone_timer_setting_calculator.sv
